// ===== rtl/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, character codes and helpers for the PDF string decoder.
// ----------------------------------------------------------------------------
package psu_pkg;

    // Output queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Character codes
    localparam logic [7:0] CH_N   = 8'h6E;  // 'n'
    localparam logic [7:0] CH_R   = 8'h72;  // 'r'
    localparam logic [7:0] CH_T   = 8'h74;  // 't'
    localparam logic [7:0] CH_B   = 8'h62;  // 'b'
    localparam logic [7:0] CH_F   = 8'h66;  // 'f'
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_BSL = 8'h5C;  // backslash

    // One result item
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       bad;
    } res_t;

    // Decoder output for one input item: up to two results
    typedef struct packed {
        res_t       r1;
        res_t       r0;
        logic [1:0] cnt;
    } dec_out_t;

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    // Returns {bad, nibble}; a non-hex character gives nibble zero, bad set
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if ((c >= 8'h30) && (c <= 8'h39))
            v = {1'b0, c[3:0]};
        else if (((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66)))
            v = {1'b0, 4'(c[3:0] + 4'd9)};
        else
            v = {1'b1, 4'h0};
        return v;
    endfunction

endpackage

// ===== rtl/psu_decode.sv =====
// ----------------------------------------------------------------------------
// psu_decode
// Escape/octal/hex state and per-byte decode; state advances on fire.
// ----------------------------------------------------------------------------
module psu_decode
    import psu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] src_byte,
    input  logic       hex_format,
    input  logic       end_of_string,
    output dec_out_t   dec
);

    logic       esc_reg,  esc_next;
    logic [1:0] ol_reg,   ol_next;
    logic [7:0] hb_reg,   hb_next;
    logic       hv_reg,   hv_next;
    logic [3:0] hn_reg,   hn_next;
    logic       np_reg,   np_next;
    logic       hbad_reg, hbad_next;

    res_t       res [2];
    logic [1:0] cnt;
    logic [4:0] hx;
    logic [7:0] oct_acc;

    assign hx      = hex_val(src_byte);
    assign oct_acc = {hb_reg[4:0], src_byte[2:0]};

    always_comb
    begin
        esc_next  = esc_reg;
        ol_next   = ol_reg;
        hb_next   = hb_reg;
        hv_next   = hv_reg;
        hn_next   = hn_reg;
        np_next   = np_reg;
        hbad_next = hbad_reg;
        res[0]    = '0;
        res[1]    = '0;
        cnt       = 2'd0;

        if (hex_format)
        begin
            if (!np_reg)
            begin
                hn_next   = hx[3:0];
                hbad_next = hx[4];
                np_next   = 1'b1;
            end
            else
            begin
                res[0]    = '{data: {hn_reg, hx[3:0]}, valid: 1'b1, last: 1'b0,
                              bad: hbad_reg | hx[4]};
                cnt       = 2'd1;
                np_next   = 1'b0;
                hn_next   = 4'h0;
                hbad_next = 1'b0;
            end
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            case (src_byte) inside
                CH_N: begin res[0] = '{CH_LF,  1'b1, 1'b0, 1'b0}; cnt = 2'd1; end
                CH_R: begin res[0] = '{CH_CR,  1'b1, 1'b0, 1'b0}; cnt = 2'd1; end
                CH_T: begin res[0] = '{CH_TAB, 1'b1, 1'b0, 1'b0}; cnt = 2'd1; end
                CH_B: begin res[0] = '{CH_BS,  1'b1, 1'b0, 1'b0}; cnt = 2'd1; end
                CH_F: begin res[0] = '{CH_FF,  1'b1, 1'b0, 1'b0}; cnt = 2'd1; end
                CH_LF, CH_CR: ;  // escaped line break is dropped
                default:
                begin
                    if (is_oct(src_byte))
                    begin
                        hb_next = {5'b0, src_byte[2:0]};
                        hv_next = 1'b1;
                        ol_next = 2'd2;
                    end
                    else
                    begin
                        res[0] = '{src_byte, 1'b1, 1'b0, 1'b0};
                        cnt    = 2'd1;
                    end
                end
            endcase
        end
        else if (hv_reg && (ol_reg != 2'd0) && is_oct(src_byte))
        begin
            // continue octal run
            ol_next = 2'(ol_reg - 2'd1);
            if (ol_reg == 2'd1)
            begin
                res[0]  = '{oct_acc, 1'b1, 1'b0, 1'b0};
                cnt     = 2'd1;
                hv_next = 1'b0;
                hb_next = 8'h00;
            end
            else
            begin
                hb_next = oct_acc;
            end
        end
        else
        begin
            // plain byte or backslash; a held octal byte is flushed first
            if (hv_reg)
            begin
                res[0]  = '{hb_reg, 1'b1, 1'b0, 1'b0};
                cnt     = 2'd1;
                hv_next = 1'b0;
                hb_next = 8'h00;
                ol_next = 2'd0;
            end
            if (src_byte == CH_BSL)
                esc_next = 1'b1;
            else
            begin
                res[cnt[0]] = '{src_byte, 1'b1, 1'b0, 1'b0};
                cnt         = 2'(cnt + 2'd1);
            end
        end

        if (end_of_string)
        begin
            if (hex_format && np_next)
            begin
                res[cnt[0]] = '{{hn_next, 4'h0}, 1'b1, 1'b0, hbad_next};
                cnt         = 2'(cnt + 2'd1);
            end
            else if (!hex_format && hv_next)
            begin
                res[cnt[0]] = '{hb_next, 1'b1, 1'b0, 1'b0};
                cnt         = 2'(cnt + 2'd1);
            end
            if (cnt == 2'd0)
            begin
                res[0] = '0;  // bare end marker
                cnt    = 2'd1;
            end
            if (cnt == 2'd2)
                res[1].last = 1'b1;
            else
                res[0].last = 1'b1;
            esc_next  = 1'b0;
            ol_next   = 2'd0;
            hb_next   = 8'h00;
            hv_next   = 1'b0;
            hn_next   = 4'h0;
            np_next   = 1'b0;
            hbad_next = 1'b0;
        end
    end

    assign dec = '{r1: res[1], r0: res[0], cnt: cnt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg  <= 1'b0;
            ol_reg   <= 2'd0;
            hb_reg   <= 8'h00;
            hv_reg   <= 1'b0;
            hn_reg   <= 4'h0;
            np_reg   <= 1'b0;
            hbad_reg <= 1'b0;
        end
        else if (fire)
        begin
            esc_reg  <= esc_next;
            ol_reg   <= ol_next;
            hb_reg   <= hb_next;
            hv_reg   <= hv_next;
            hn_reg   <= hn_next;
            np_reg   <= np_next;
            hbad_reg <= hbad_next;
        end
    end

endmodule

// ===== rtl/psu_out_fifo.sv =====
// ----------------------------------------------------------------------------
// psu_out_fifo
// Small result queue; takes up to two results per cycle, gives one while the output is not stalled.
// ----------------------------------------------------------------------------
module psu_out_fifo
    import psu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dec_out_t push,
    output logic     room,
    output logic     out_valid,
    input  logic     out_stall,
    output res_t     head
);

    res_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg,  count_next;
    logic               pop;
    logic [FIFO_AW-1:0] wr_ptr_p1;

    assign out_valid = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign wr_ptr_p1 = FIFO_AW'(wr_ptr_reg + 1'b1);

    // room for two results, counting this cycle's pop
    assign room = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2))
               || ((count_reg == (FIFO_AW+1)'(FIFO_DEPTH - 1)) && pop);

    always_comb
    begin
        wr_ptr_next = FIFO_AW'(wr_ptr_reg + FIFO_AW'(push.cnt));
        rd_ptr_next = pop ? FIFO_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = (FIFO_AW+1)'(count_reg + (FIFO_AW+1)'(push.cnt)
                                  - (FIFO_AW+1)'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.cnt == 2'd2)
            mem_reg[wr_ptr_p1] <= push.r1;
    end

endmodule

// ===== rtl/pdf_string_unescape.sv =====
// ----------------------------------------------------------------------------
// pdf_string_unescape
// PDF literal/hex string body decoder, one source byte per item.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register stage, is decoded when
//   the decoder fires, and its results are registered in the result queue.
// Throughput: one item per cycle while items give at most one result each and
//   results drain; one result leaves per cycle while out_stall is low. Input
//   stalls while the result queue cannot take a worst-case two results.
// Reset: rst_n async, active low; clears escape/octal/hex state, input stage
//   and result queue. No clearing pass is needed.
// ----------------------------------------------------------------------------
module pdf_string_unescape
    import psu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] src_byte,
    input  logic       hex_format,
    input  logic       end_of_string,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last_of_string,
    output logic       bad_digit
);

    // Input register stage: one item waits here for the decoder.
    logic       in_vld_reg,  in_vld_next;
    logic [7:0] byte_reg;
    logic       hex_reg;
    logic       eos_reg;

    logic       accept;
    logic       fire;
    logic       room;
    dec_out_t   dec;
    dec_out_t   push;
    res_t       head;

    // The decoder fires when the queue can absorb a worst-case two results.
    assign fire     = in_vld_reg && room;
    assign in_stall = in_vld_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= src_byte;
            hex_reg  <= hex_format;
            eos_reg  <= end_of_string;
        end
    end

    // Escape / octal / hex nibble state machine and per-byte decode
    psu_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .src_byte      (byte_reg),
        .hex_format    (hex_reg),
        .end_of_string (eos_reg),
        .dec           (dec)
    );

    // Nothing is pushed unless the decoder fires.
    always_comb
    begin
        push = dec;
        if (!fire)
            push.cnt = 2'd0;
    end

    // Result queue: decouples the output stall from the input stage.
    psu_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign out_byte       = head.data;
    assign byte_valid     = head.valid;
    assign last_of_string = head.last;
    assign bad_digit      = head.bad;

endmodule
